/* hdl/nnrs_pkg.sv */
// ----------------------------------------------------------------------------
// nnrs_pkg
// shared widths, register indexes, reset values and run entry types for the
// nearest neighbor row stretch unit
// ----------------------------------------------------------------------------
package nnrs_pkg;

  // configuration port
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 2'd2;

  localparam logic [CFG_W-1:0] SOURCE_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RESET = 13'd480;
  localparam logic [CFG_W-1:0] SCALE_FACTOR_RESET  = 13'd256;

  // geometry
  localparam int MAX_WIDTH       = 4096;
  localparam int SCALE_FRAC_BITS = 8;
  localparam int MAX_SCALE       = 16;
  localparam int SCALE_LIMIT     = MAX_SCALE << SCALE_FRAC_BITS;

  localparam int COLOR_W = 8;
  localparam int COL_W   = 12;                // source column and row counters
  localparam int POS_W   = 16;                // output column position
  localparam int NW_W    = POS_W + 1;         // stretched width, up to 65536
  localparam int PROD_W  = 2 * CFG_W;         // width times scale
  localparam int PEND_W  = PROD_W - SCALE_FRAC_BITS;

  // results per source pixel
  localparam int RESULT_CAP = 16;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);
  localparam int K_W        = $clog2(RESULT_CAP);

  localparam int RUN_QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [POS_W-1:0]   start;
    logic [CNT_W-1:0]   count;
    logic [NW_W-1:0]    new_width;
    logic               last_row;
  } run_entry_t;

  typedef struct packed {
    logic       valid;
    run_entry_t entry;
  } run_slot_t;

  // width or height, held to 1 .. MAX_WIDTH
  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(MAX_WIDTH)) begin
      r = CFG_W'(MAX_WIDTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // scale, held to 1/256 .. MAX_SCALE in fixed point
  function automatic logic [CFG_W-1:0] clamp_scale(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (v > CFG_W'(SCALE_LIMIT)) begin
      r = CFG_W'(SCALE_LIMIT);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* hdl/nnrs_front.sv */
// ----------------------------------------------------------------------------
// nnrs_front
// configuration registers, pixel intake and run computation: start column,
// run length and row/frame position for each source pixel
// ----------------------------------------------------------------------------
module nnrs_front import nnrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COLOR_W-1:0]   in_red,
  input  logic [COLOR_W-1:0]   in_green,
  input  logic [COLOR_W-1:0]   in_blue,
  output run_slot_t            push,
  input  logic                 full
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_PUSH = 3'b100
  } front_state_t;

  front_state_t state;

  logic [CFG_W-1:0] source_width;
  logic [CFG_W-1:0] source_height;
  logic [CFG_W-1:0] scale_factor;

  logic [COL_W-1:0] source_column;
  logic [COL_W-1:0] source_row;
  logic [POS_W-1:0] next_position;

  logic [COLOR_W-1:0] pix_red;
  logic [COLOR_W-1:0] pix_green;
  logic [COLOR_W-1:0] pix_blue;
  logic [NW_W-1:0]    new_width;
  logic [PEND_W-1:0]  prod_end;
  logic               last_in_row;
  logic               last_row;

  logic [CFG_W-1:0]  w_c;
  logic [CFG_W-1:0]  h_c;
  logic [CFG_W-1:0]  s_c;
  logic [CFG_W-1:0]  col_inc;
  logic [CFG_W-1:0]  row_inc;
  logic [PROD_W-1:0] nw_prod;
  logic [PROD_W-1:0] end_prod;

  logic [NW_W-1:0]  run_end;
  logic [NW_W-1:0]  run_diff;
  logic [CNT_W-1:0] run_count;
  logic             push_done;

  assign w_c     = clamp_dim(source_width);
  assign h_c     = clamp_dim(source_height);
  assign s_c     = clamp_scale(scale_factor);
  assign col_inc = {1'b0, source_column} + CFG_W'(1);
  assign row_inc = {1'b0, source_row} + CFG_W'(1);
  assign nw_prod  = {{CFG_W{1'b0}}, w_c} * {{CFG_W{1'b0}}, s_c};
  assign end_prod = {{CFG_W{1'b0}}, col_inc} * {{CFG_W{1'b0}}, s_c};

  assign in_stall = (state != ST_IDLE);

  // run end and length from the registered products
  always_comb begin
    if (last_in_row) begin
      run_end = new_width;
    end else if (prod_end > {{(PEND_W-NW_W){1'b0}}, new_width}) begin
      run_end = new_width;
    end else begin
      run_end = prod_end[NW_W-1:0];
    end
    if (run_end > {1'b0, next_position}) begin
      run_diff = run_end - {1'b0, next_position};
    end else begin
      run_diff = '0;
    end
    if (run_diff > NW_W'(RESULT_CAP)) begin
      run_count = CNT_W'(RESULT_CAP);
    end else begin
      run_count = run_diff[CNT_W-1:0];
    end
  end

  assign push_done = (run_count == '0) || !full;

  always_comb begin
    push.valid           = (state == ST_PUSH) && (run_count != '0) && !full;
    push.entry.red       = pix_red;
    push.entry.green     = pix_green;
    push.entry.blue      = pix_blue;
    push.entry.start     = next_position;
    push.entry.count     = run_count;
    push.entry.new_width = new_width;
    push.entry.last_row  = last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SOURCE_WIDTH_RESET;
      source_height <= SOURCE_HEIGHT_RESET;
      scale_factor  <= SCALE_FACTOR_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  source_width  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height <= cfg_data;
        REG_SCALE_FACTOR:  scale_factor  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      source_column <= '0;
      source_row    <= '0;
      next_position <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_done) begin
            state <= ST_IDLE;
            if (last_in_row) begin
              source_column <= '0;
              next_position <= '0;
              source_row    <= last_row ? '0 : row_inc[COL_W-1:0];
            end else begin
              source_column <= col_inc[COL_W-1:0];
              next_position <= run_end[POS_W-1:0];
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // pixel capture and multiply stage
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      pix_red   <= in_red;
      pix_green <= in_green;
      pix_blue  <= in_blue;
    end
    if (state == ST_MUL) begin
      new_width   <= nw_prod[SCALE_FRAC_BITS +: NW_W];
      prod_end    <= end_prod[SCALE_FRAC_BITS +: PEND_W];
      last_in_row <= (col_inc >= w_c);
      last_row    <= (row_inc >= h_c);
    end
  end

endmodule

/* hdl/nnrs_queue.sv */
// ----------------------------------------------------------------------------
// nnrs_queue
// small first-in first-out queue of runs between front and back
// ----------------------------------------------------------------------------
module nnrs_queue import nnrs_pkg::*; #(
  parameter int DEPTH = RUN_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  run_slot_t push,
  output logic      full,
  output run_slot_t head,
  input  logic      pop
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  run_entry_t        slots [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full       = (fill == FILL_W'(DEPTH));
  assign head.valid = (fill != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + ADDR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + ADDR_W'(1);
      end
      if (push.valid && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push.valid) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

/* hdl/nnrs_back.sv */
// ----------------------------------------------------------------------------
// nnrs_back
// expands each queued run into output pixels, one per cycle while the
// output is not stalled, through an output register
// ----------------------------------------------------------------------------
module nnrs_back import nnrs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  run_slot_t          head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_blue,
  output logic [POS_W-1:0]   out_column,
  output logic               run_last,
  output logic               row_end,
  output logic               frame_end
);

  logic [K_W-1:0]   k;
  logic             load;
  logic             last_k;
  logic [NW_W-1:0]  column;
  logic [NW_W-1:0]  column_inc;
  logic             at_row_end;

  assign load       = head.valid && (!out_valid || !out_stall);
  assign last_k     = (({1'b0, k}) + CNT_W'(1)) == head.entry.count;
  assign pop        = load && last_k;
  assign column     = {1'b0, head.entry.start} + NW_W'(k);
  assign column_inc = column + NW_W'(1);
  assign at_row_end = (column_inc == head.entry.new_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        k         <= last_k ? '0 : k + K_W'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_red    <= head.entry.red;
      out_green  <= head.entry.green;
      out_blue   <= head.entry.blue;
      out_column <= column[POS_W-1:0];
      run_last   <= last_k;
      row_end    <= at_row_end;
      frame_end  <= at_row_end && head.entry.last_row;
    end
  end

endmodule

/* hdl/nearest_neighbor_row_stretch_unit.sv */
// path: a pixel is captured, its products registered and its run queued, then
//   each result leaves through the back's output register; the front stalls
//   its input until the run is queued; the back emits one result per cycle
//   while the output is not stalled, up to 16 results per pixel at the largest scale
// reset: synchronous, clears counters, queue and output valid; configuration
//   returns to 640 x 480 at scale 1.0; no clearing pass
// ----------------------------------------------------------------------------
// nearest_neighbor_row_stretch_unit
// nearest neighbor horizontal stretch of rgb rows by an unsigned q5.8 factor
// ----------------------------------------------------------------------------
module nearest_neighbor_row_stretch_unit import nnrs_pkg::*; #(
  parameter int QUEUE_DEPTH = RUN_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // source pixels
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COLOR_W-1:0]   in_red,
  input  logic [COLOR_W-1:0]   in_green,
  input  logic [COLOR_W-1:0]   in_blue,
  // stretched pixels
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [COLOR_W-1:0]   out_red,
  output logic [COLOR_W-1:0]   out_green,
  output logic [COLOR_W-1:0]   out_blue,
  output logic [POS_W-1:0]     out_column,
  output logic                 run_last,
  output logic                 row_end,
  output logic                 frame_end
);

  // front to queue: one run per source pixel that gives any result
  run_slot_t push;
  logic      full;
  // queue to back: oldest pending run
  run_slot_t head;
  logic      pop;

  // front: config, column/row tracking, run start and length
  nnrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .push      (push),
    .full      (full)
  );

  // decouples pixel intake from result emission
  nnrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  // back: one output column per cycle unless stalled, flags per transaction
  nnrs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_column (out_column),
    .run_last   (run_last),
    .row_end    (row_end),
    .frame_end  (frame_end)
  );

endmodule

/* test/nnrs_stretch_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnrs_stretch_checker
// watches the register port and both pixel channels of the row stretch unit,
// predicts every stretched pixel and compares it with what comes out
// ----------------------------------------------------------------------------
module nnrs_stretch_checker import nnrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [COLOR_W-1:0]   in_red,
  input  logic [COLOR_W-1:0]   in_green,
  input  logic [COLOR_W-1:0]   in_blue,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [COLOR_W-1:0]   out_red,
  input  logic [COLOR_W-1:0]   out_green,
  input  logic [COLOR_W-1:0]   out_blue,
  input  logic [POS_W-1:0]     out_column,
  input  logic                 run_last,
  input  logic                 row_end,
  input  logic                 frame_end,
  output int                   fault_count,
  output int                   pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [POS_W-1:0]   column;
    logic               run_last;
    logic               row_end;
    logic               frame_end;
  } stretched_px_t;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [CFG_W-1:0] scale_reg;
  logic [COL_W-1:0] src_col;
  logic [COL_W-1:0] src_row;
  logic [POS_W-1:0] next_pos;

  stretched_px_t expected_pixels[$];
  stretched_px_t seen_px;
  stretched_px_t want_px;

  initial begin
    fault_count = 0;
    pending = 0;
  end

  function automatic int unsigned fit_range(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic string show(input stretched_px_t p);
    return $sformatf("rgb %02h/%02h/%02h col %0d last %b row %b frame %b",
                     p.red, p.green, p.blue, p.column, p.run_last, p.row_end,
                     p.frame_end);
  endfunction

  // expected stretched pixels of one source pixel, then advance the counters
  task automatic stretch_pixel(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                               input logic [COLOR_W-1:0] b);
    int unsigned w, h, s, new_w, col, start, stop, count, k;
    bit row_done, last_row, at_end;
    stretched_px_t px;
    w = fit_range(32'(width_reg), 1, MAX_WIDTH);
    h = fit_range(32'(height_reg), 1, MAX_WIDTH);
    s = fit_range(32'(scale_reg), 1, SCALE_LIMIT);
    new_w = (w * s) >> SCALE_FRAC_BITS;
    col = 32'(src_col);
    row_done = (col + 1 >= w);
    last_row = (int'(src_row) + 1 >= h);
    start = 32'(next_pos);
    if (row_done) begin
      stop = new_w;
    end else begin
      stop = ((col + 1) * s) >> SCALE_FRAC_BITS;
      if (stop > new_w) stop = new_w;
    end
    count = (stop > start) ? stop - start : 0;
    if (count > RESULT_CAP) count = RESULT_CAP;
    for (k = 0; k < count; k++) begin
      at_end = (start + k + 1 == new_w);
      px = {r, g, b, POS_W'(start + k), (k + 1 == count), at_end, at_end && last_row};
      expected_pixels.push_back(px);
    end
    if (row_done) begin
      src_col = '0;
      next_pos = '0;
      src_row = last_row ? '0 : src_row + 1'b1;
    end else begin
      src_col = src_col + 1'b1;
      next_pos = POS_W'(stop);
    end
  endtask

  task automatic report(input string what);
    fault_count++;
    if (fault_count <= REPORT_LIMIT) $display("checker: %0t %s", $time, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg = SOURCE_WIDTH_RESET;
      height_reg = SOURCE_HEIGHT_RESET;
      scale_reg = SCALE_FACTOR_RESET;
      src_col = '0;
      src_row = '0;
      next_pos = '0;
      expected_pixels.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen_px = {out_red, out_green, out_blue, out_column, run_last, row_end, frame_end};
        if (expected_pixels.size() == 0) begin
          report({"unexpected pixel: ", show(seen_px)});
        end else begin
          want_px = expected_pixels.pop_front();
          if (seen_px !== want_px) begin
            report({"mismatch: expected ", show(want_px), ", got ", show(seen_px)});
          end
        end
      end
      if (in_valid && !in_stall) stretch_pixel(in_red, in_green, in_blue);
      if (cfg_write) begin
        case (cfg_index)
          REG_SOURCE_WIDTH:  width_reg = cfg_data;
          REG_SOURCE_HEIGHT: height_reg = cfg_data;
          REG_SCALE_FACTOR:  scale_reg = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_pixels.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives rgb rows through the row stretch unit under several geometries,
// with random gaps and stalls on both channels; a checker beside the block
// predicts every stretched pixel and counts mismatches
// ----------------------------------------------------------------------------
module tb;
  import nnrs_pkg::*;

  localparam int IDLE_MAX     = 17;     // longest random gap or stall per transaction
  localparam int DRAIN_CYCLES = 12;     // settle time once nothing is expected
  localparam int LONG_HOLD    = 300;    // long receiver hold-off
  localparam int RANDOM_ITEMS = 200;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [COLOR_W-1:0]   in_red;
  logic [COLOR_W-1:0]   in_green;
  logic [COLOR_W-1:0]   in_blue;
  logic                 out_valid;
  logic                 out_stall;
  logic [COLOR_W-1:0]   out_red;
  logic [COLOR_W-1:0]   out_green;
  logic [COLOR_W-1:0]   out_blue;
  logic [POS_W-1:0]     out_column;
  logic                 run_last;
  logic                 row_end;
  logic                 frame_end;

  // idling controls for the sender and the receiver
  bit tx_idle;
  bit rx_idle;
  bit hold_request;

  int fault_count;
  int pending;
  int random_items;

  nearest_neighbor_row_stretch_unit dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_column(out_column), .run_last(run_last), .row_end(row_end),
    .frame_end(frame_end)
  );

  nnrs_stretch_checker watch (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_column(out_column), .run_last(run_last), .row_end(row_end),
    .frame_end(frame_end),
    .fault_count(fault_count), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // one source pixel transaction, with an optional random gap in front;
  // valid stays high across back-to-back transactions
  task automatic send_pixel(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                            input logic [COLOR_W-1:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_pixel();
    send_pixel(COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
               COLOR_W'($urandom_range(0, 255)));
  endtask

  // stop offering pixels and wait until every predicted pixel is out;
  // the extra cycles cover a pixel that makes no output but is still in flight
  task automatic drain_block();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all three registers, only while the block is idle
  task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] s);
    cfg_write <= 1'b1;
    cfg_index <= REG_SOURCE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_SOURCE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_SCALE_FACTOR;
    cfg_data  <= s;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // receiver: random stall before each stretched pixel, plus one long hold-off
  initial begin
    int n;
    out_stall = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      n = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int phase_items;
    logic [CFG_W-1:0] w, h, s;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_SOURCE_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_request = 1'b0;
    random_items = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset geometry, 640 wide at 1.0: color extremes
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    drain_block();

    // width dropped under the current column: pixel closes the row, empty run
    set_geometry(13'd2, 13'd480, 13'd256);
    send_pixel(8'h55, 8'hAA, 8'h55);
    drain_block();

    // two rows of two at the largest scale, frame end on the first of them
    set_geometry(13'd2, 13'd2, 13'd4096);
    repeat (4) send_random_pixel();
    drain_block();

    // scale zero taken as the smallest step: stretched width is zero
    set_geometry(13'd3, 13'd2, 13'd0);
    repeat (3) send_random_pixel();
    drain_block();

    // shrink by half: some pixels get overwritten, the row ends with no output
    set_geometry(13'd5, 13'd2, 13'd128);
    repeat (5) send_random_pixel();
    drain_block();

    // zero width and height taken as one, scale saturated: every pixel a frame
    set_geometry(13'd0, 13'd0, 13'd8191);
    repeat (2) send_random_pixel();
    drain_block();

    // oversized width taken as the maximum, then a scale jump mid-row gives a
    // run longer than the cap
    set_geometry(13'd8191, 13'd3, 13'd256);
    repeat (2) send_random_pixel();
    drain_block();
    set_geometry(13'd8191, 13'd3, 13'd4096);
    send_random_pixel();
    drain_block();

    // width lowered to the current column: run goes to the stretched row end
    set_geometry(13'd4, 13'd3, 13'd4096);
    send_random_pixel();

    // random phases, each with its own geometry and idling
    while (random_items < RANDOM_ITEMS) begin
      drain_block();
      case ($urandom_range(0, 7))
        0: w = CFG_W'($urandom_range(0, 8191));
        1: w = ($urandom_range(0, 1) != 0) ? 13'd0 : 13'd4096;
        default: w = CFG_W'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 5))
        0: h = CFG_W'($urandom_range(0, 8191));
        default: h = CFG_W'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0: s = CFG_W'($urandom_range(0, 8191));
        1: s = CFG_W'($urandom_range(1, 255));
        2: s = CFG_W'($urandom_range(256, 1024));
        3: s = CFG_W'($urandom_range(3072, 4096));
        default: s = CFG_W'($urandom_range(1, 4096));
      endcase
      set_geometry(w, h, s);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      // first phase: receiver holds off while pixels keep coming, so the
      // block fills up and stalls its input
      if (random_items == 0) begin
        tx_idle = 1'b0;
        hold_request = 1'b1;
      end
      phase_items = $urandom_range(6, 20);
      repeat (phase_items) begin
        send_random_pixel();
        random_items++;
      end
    end

    drain_block();
    if (fault_count == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
